// ----- hw/rtl/tlv_key_value_extractor_assert.svh -----
`ifndef TLV_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define TLV_KEY_VALUE_EXTRACTOR_ASSERT_SVH

// Same-cycle and next-cycle implication checks, clocked on clk, held off during reset.
`ifndef NO_ASSERTIONS
`define TLVKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TLVKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLVKV_ASSERT_NOW(lbl, ante, cons, msg)
`define TLVKV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/tlvkv_pkg.sv -----
package tlvkv_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KEY_TEXT_W = 64;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = 2'd2;

  localparam logic [1:0] KIND_TENT  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic [7:0] copied_count;
    logic       end_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- hw/rtl/tlv_key_value_extractor.sv -----
// Channel  Dir  tdata                                  tuser      tlast
// in_      in   [7:0] data_byte                        -          last_byte
// out_     out  [7:0] value_byte, [15:8] copied_count  [1:0] kind end_of_run
// cfg_     in   write enable, index, 64-bit data       -          -
//
// One request per cycle while the queue has room: a byte is registered and parsed,
// and its results (none, one or two) are pushed into a four-entry result queue.
// Results leave one per cycle while out_tready holds; two-result bytes limit the rate.
// rst_n is synchronous, active low; it clears parse state and config registers.
// in_tready drops only while the queue has fewer than two free entries.
module tlv_key_value_extractor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlvkv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvkv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // [7:0] data_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata, // [7:0] value_byte, [15:8] copied_count
  output logic [1:0]                       out_tuser, // [1:0] kind
  output logic                             out_tlast
);

  tlvkv_pkg::push_t push;
  tlvkv_pkg::res_t  out_res;
  logic             room;

  tlvkv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .room      (room),
    .push      (push)
  );

  tlvkv_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.copied_count, out_res.value_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.end_of_run;

endmodule

// ----- hw/rtl/tlvkv_res_fifo.sv -----
`include "tlv_key_value_extractor_assert.svh"

module tlvkv_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  tlvkv_pkg::push_t push,
  output logic           room,
  output logic           out_tvalid,
  input  logic           out_tready,
  output tlvkv_pkg::res_t  out_res
);

  tlvkv_pkg::res_t mem_r [tlvkv_pkg::RES_DEPTH];
  logic [tlvkv_pkg::RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [tlvkv_pkg::RES_PTR_W-1:0] wr_ptr_p1;
  logic [tlvkv_pkg::RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_res    = mem_r[rd_ptr_r];
  assign room       = (cnt_r <= tlvkv_pkg::RES_CNT_W'(tlvkv_pkg::RES_DEPTH - 2));
  assign wr_ptr_p1  = wr_ptr_r + tlvkv_pkg::RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + tlvkv_pkg::RES_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + tlvkv_pkg::RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + tlvkv_pkg::RES_CNT_W'(push.n) - tlvkv_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  `TLVKV_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= tlvkv_pkg::RES_CNT_W'(tlvkv_pkg::RES_DEPTH), "result queue overfilled")
  `TLVKV_ASSERT_NOW(a_push_room, push.n != 2'd0, room, "push without room")
  `TLVKV_ASSERT_NEXT(a_pop_only, pop && (push.n == 2'd0), cnt_r == $past(cnt_r) - tlvkv_pkg::RES_CNT_W'(1), "pop did not drain")

endmodule

// ----- hw/rtl/tlvkv_parser.sv -----
`include "tlv_key_value_extractor_assert.svh"

module tlvkv_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlvkv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvkv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic                             room,
  output tlvkv_pkg::push_t                 push
);

  typedef enum logic [2:0] {
    PH_KEYLEN, PH_KEY, PH_VALLEN, PH_VALUE, PH_SKIP, PH_DONE
  } phase_t;

  logic [3:0]                        key_len_r;
  logic [tlvkv_pkg::KEY_TEXT_W-1:0]  key_text_r;
  logic [7:0]                        limit_r;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       adv;

  phase_t     phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic       eq_r, eq_nxt;
  logic [7:0] copied_r, copied_nxt;

  logic       tent, found, none;
  logic [7:0] lane;
  tlvkv_pkg::res_t tent_rec, end_rec;

  assign adv       = in_v_r && room;
  assign in_tready = !in_v_r || room;
  assign lane      = key_text_r[{pos_r[tlvkv_pkg::KEY_IDX_W-1:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r  <= '0;
      key_text_r <= '0;
      limit_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlvkv_pkg::REG_KEY_LENGTH:  key_len_r  <= cfg_data[3:0];
        tlvkv_pkg::REG_KEY_TEXT:    key_text_r <= cfg_data;
        tlvkv_pkg::REG_VALUE_LIMIT: limit_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    eq_nxt     = eq_r;
    copied_nxt = copied_r;
    tent       = 1'b0;
    found      = 1'b0;
    none       = 1'b0;
    unique case (phase_r)
      PH_KEYLEN: begin
        eq_nxt    = (in_byte_r == {4'b0, key_len_r}) &&
                    (key_len_r <= 4'(tlvkv_pkg::KEY_BYTES));
        pos_nxt   = '0;
        left_nxt  = in_byte_r;
        phase_nxt = (in_byte_r == 8'd0) ? PH_VALLEN : PH_KEY;
      end
      PH_KEY: begin
        eq_nxt   = eq_r && (pos_r < 8'(tlvkv_pkg::KEY_BYTES)) && (lane == in_byte_r);
        pos_nxt  = pos_r + 8'd1;
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1) begin
          phase_nxt = PH_VALLEN;
        end
      end
      PH_VALLEN: begin
        if (eq_r) begin
          copied_nxt = '0;
          pos_nxt    = '0;
          left_nxt   = in_byte_r;
          if (in_byte_r == 8'd0) begin
            found     = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end else if (in_byte_r == 8'd0) begin
          phase_nxt = PH_KEYLEN;
        end else begin
          left_nxt  = in_byte_r;
          phase_nxt = PH_SKIP;
        end
      end
      PH_VALUE: begin
        if (pos_r < limit_r) begin
          tent       = 1'b1;
          copied_nxt = copied_r + 8'd1;
        end
        pos_nxt  = pos_r + 8'd1;
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1) begin
          found     = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      PH_SKIP: begin
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1) begin
          phase_nxt = PH_KEYLEN;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase

    // last byte: report a miss unless the key was found, then drop back to the start of a dictionary
    if (in_last_r) begin
      none       = !found && (phase_r != PH_DONE);
      phase_nxt  = PH_KEYLEN;
      left_nxt   = '0;
      pos_nxt    = '0;
      eq_nxt     = 1'b0;
      copied_nxt = '0;
    end
  end

  always_comb begin
    tent_rec.kind         = tlvkv_pkg::KIND_TENT;
    tent_rec.value_byte   = in_byte_r;
    tent_rec.copied_count = '0;
    tent_rec.end_of_run   = !(found || none);
    end_rec.kind          = found ? tlvkv_pkg::KIND_FOUND : tlvkv_pkg::KIND_NONE;
    end_rec.value_byte    = '0;
    end_rec.copied_count  = found ? (copied_r + 8'(tent)) : 8'd0;
    end_rec.end_of_run    = 1'b1;
    push.r0 = tent ? tent_rec : end_rec;
    push.r1 = end_rec;
    push.n  = adv ? (2'(tent) + 2'(found || none)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KEYLEN;
      left_r   <= '0;
      pos_r    <= '0;
      eq_r     <= 1'b0;
      copied_r <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      eq_r     <= eq_nxt;
      copied_r <= copied_nxt;
    end
  end

  `TLVKV_ASSERT_NEXT(a_last_clears, adv && in_last_r, (phase_r == PH_KEYLEN) && (copied_r == 8'd0), "last byte did not clear state")
  `TLVKV_ASSERT_NOW(a_done_silent, adv && (phase_r == PH_DONE), push.n == 2'd0, "result after match")
  `TLVKV_ASSERT_NOW(a_pair_order, push.n == 2'd2, (push.r0.kind == tlvkv_pkg::KIND_TENT) && !push.r0.end_of_run, "bad result pair")

endmodule
